// ===== rtl/dlcs_pkg.sv =====
// dlcs_pkg: shared types, constants and the base decoder of the low-complexity score block.
// Used by dlcs_datapath, dlcs_ctrl and dust_low_complexity_score; no dependencies.
package dlcs_pkg;

   // Fixed field widths of the request, response and register port.
   localparam int BASE_W       = 8;
   localparam int SCORE_W      = 7;
   localparam int PAIR_COUNT_W = 11;
   localparam int WINDOW_CFG_W = 7;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // Three-base words are six bits, so the count table has 64 entries.
   localparam int WORD_W    = 6;
   localparam int NUM_WORDS = 64;

   // Window limits and the window loaded at reset.
   localparam int WINDOW_MIN   = 3;
   localparam int WINDOW_RESET = 64;

   // Score is 200 * S / D; doubling numerator and denominator gives round half up.
   localparam int SCORE_SCALE = 400;
   localparam int SCORE_MAX   = 100;

   // Register index of window_size (address bit two selects the register).
   localparam logic CSR_IDX_WINDOW_SIZE = 1'b0;

   typedef struct packed {
      logic [BASE_W-1:0] base;
      logic              has_base;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [SCORE_W-1:0]      dust_score;
      logic [PAIR_COUNT_W-1:0] pair_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LEAVE_RD,
      ST_LEAVE_WR,
      ST_ENTER_RD,
      ST_ENTER_WR,
      ST_FIN_MUL,
      ST_FIN_NUM,
      ST_FIN_START,
      ST_FIN_WAIT,
      ST_FIN_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic leave_rd;
      logic leave_wr;
      logic enter_rd;
      logic enter_wr;
      logic fin_mul;
      logic fin_num;
      logic div_start;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic in_word;
      logic in_slide;
      logic in_last;
      logic last;
      logic d_zero;
      logic div_done;
      logic rsp_free;
   } status_type;

   // Returns {hit, code}: A=0, C=1, G=2, T=3 in either case; anything else misses.
   function automatic logic [2:0] base_decode(input logic [BASE_W-1:0] c);
      logic [2:0] r;
      case (c)
         8'h41, 8'h61: r = 3'b100;
         8'h43, 8'h63: r = 3'b101;
         8'h47, 8'h67: r = 3'b110;
         8'h54, 8'h74: r = 3'b111;
         default:      r = 3'b000;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/dlcs_divider.sv =====
// dlcs_divider: restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file; instantiated by dlcs_datapath.
module dlcs_divider #(
   parameter int NUM_W = 20,
   parameter int DEN_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_shift;
   logic [DEN_W:0]   rem_diff;
   logic             fits;

   // One trial subtraction of the shifted remainder.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, divisor};
      fits      = !rem_diff[DEN_W];
   end

   // Next-state logic for the iteration.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Dividend, quotient and remainder.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/dlcs_datapath.sv =====
// dlcs_datapath: word counts, window ring, pair scores, final scaling and the result register.
// Depends on dlcs_pkg and dlcs_divider; driven by commands from dlcs_ctrl.
module dlcs_datapath #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dlcs_pkg::cmd_type                    cmd,
   output dlcs_pkg::status_type                 status,
   input  dlcs_pkg::req_type                    req_data,
   input  logic [dlcs_pkg::WINDOW_CFG_W-1:0]    window_size,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output dlcs_pkg::rsp_type                    rsp_data
);

   localparam int WIN_W     = $clog2(MAX_WINDOW + 1);
   localparam int RING_AW   = $clog2(MAX_WINDOW);
   localparam int WIDX_W    = $clog2(MAX_WINDOW + 4);
   localparam int MAX_PAIRS = MAX_WINDOW * (MAX_WINDOW - 1) / 2;
   localparam int PAIR_W    = $clog2(MAX_PAIRS + 1);
   localparam int CNT_W     = WIN_W;
   localparam int D_W       = 2 * WIN_W;
   localparam int NUM_W     = PAIR_W + 9;
   localparam int DEN_W     = D_W + 1;
   localparam int WORD_W    = dlcs_pkg::WORD_W;
   localparam int WORDS     = dlcs_pkg::NUM_WORDS;
   localparam int CFG_W     = dlcs_pkg::WINDOW_CFG_W;
   localparam int SW        = dlcs_pkg::SCORE_W;
   localparam int PCW       = dlcs_pkg::PAIR_COUNT_W;

   // Clamp a window_size value to the supported range.
   function automatic logic [WIN_W-1:0] clamp_window(input logic [CFG_W-1:0] ws);
      logic [WIN_W-1:0] r;
      if (int'(ws) < dlcs_pkg::WINDOW_MIN) begin
         r = WIN_W'(dlcs_pkg::WINDOW_MIN);
      end else if (int'(ws) > MAX_WINDOW) begin
         r = WIN_W'(MAX_WINDOW);
      end else begin
         r = WIN_W'(ws);
      end
      return r;
   endfunction

   // Sequence state.
   logic [WIN_W-1:0]   win_ff, win_in;
   logic [WORD_W-1:0]  cur_ff, cur_in;
   logic [WIDX_W-1:0]  widx_ff, widx_in;
   logic [RING_AW-1:0] ring_pos_ff, ring_pos_in;
   logic [PAIR_W-1:0]  run_ff, run_in;
   logic [PAIR_W-1:0]  peak_ff, peak_in;
   logic               slide_ff, slide_in;
   logic               last_ff, last_in;
   logic [RING_AW-1:0] k_ff, k_in;

   // Final scaling.
   logic [PAIR_W-1:0]  s_ff, s_in;
   logic [D_W-1:0]     d_ff, d_in;
   logic [NUM_W-1:0]   num_ff, num_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   dlcs_pkg::rsp_type  rsp_data_ff, rsp_data_in;

   // Count table and window ring.
   logic [CNT_W-1:0]   cnt_mem [WORDS];
   logic [WORD_W-1:0]  ring_mem [MAX_WINDOW];
   logic [WORDS-1:0]   cnt_vld_ff, cnt_vld_in;
   logic [CNT_W-1:0]   cnt_q_ff;
   logic [WORD_W-1:0]  cnt_addr_ff;
   logic [WORD_W-1:0]  ring_q_ff;

   logic [2:0]         bcode;
   logic               hit;
   logic [WORD_W-1:0]  cur_next;
   logic [WIDX_W-1:0]  win_lim;
   logic [WIDX_W-1:0]  widx_next;
   logic [RING_AW-1:0] ring_k;
   logic [WIN_W-1:0]   k_plus;
   logic [WORD_W-1:0]  cnt_rd_addr;
   logic [CNT_W-1:0]   cnt_eff;
   logic               cnt_we;
   logic [CNT_W-1:0]   cnt_wdata;
   logic [PAIR_W-1:0]  run_add;
   logic               seq_slide;
   logic               n_pos;
   logic [WIN_W-1:0]   n_val;
   logic [WIN_W-1:0]   mul_a;
   logic [WIN_W-1:0]   mul_b;
   logic               div_done;
   logic [NUM_W-1:0]   quotient;
   logic [SW-1:0]      score_sat;

   // Decode of the incoming character and the word position it leads to.
   always_comb begin
      bcode     = dlcs_pkg::base_decode(req_data.base);
      hit       = req_data.has_base && bcode[2];
      cur_next  = {cur_ff[WORD_W-3:0], bcode[1:0]};
      win_lim   = WIDX_W'(win_ff) + WIDX_W'(3);
      widx_next = (widx_ff >= win_lim) ? widx_ff : widx_ff + 1'b1;
      ring_k    = (WIN_W'(ring_pos_ff) >= win_ff) ? '0 : ring_pos_ff;
      k_plus    = WIN_W'(k_ff) + 1'b1;
   end

   // Count table read port and the value a missing entry stands for.
   always_comb begin
      cnt_rd_addr = cmd.leave_rd ? ring_q_ff : cur_ff;
      cnt_eff     = cnt_vld_ff[cnt_addr_ff] ? cnt_q_ff : '0;
      cnt_we      = (cmd.leave_wr && (cnt_eff != '0)) || cmd.enter_wr;
      cnt_wdata   = cmd.leave_wr ? cnt_eff - 1'b1 : cnt_eff + 1'b1;
      run_add     = run_ff + PAIR_W'(cnt_eff);
   end

   // Operands of the denominator product.
   always_comb begin
      seq_slide = widx_ff >= win_lim;
      n_pos     = widx_ff > WIDX_W'(3);
      n_val     = WIN_W'(widx_ff - WIDX_W'(3));
      mul_a     = seq_slide ? win_ff : n_val;
      mul_b     = seq_slide ? win_ff - 1'b1 : n_val + 1'b1;
      score_sat = (quotient > NUM_W'(dlcs_pkg::SCORE_MAX)) ?
                  SW'(dlcs_pkg::SCORE_MAX) : SW'(quotient);
   end

   // Next values of all registers.
   always_comb begin
      win_in       = win_ff;
      cur_in       = cur_ff;
      widx_in      = widx_ff;
      ring_pos_in  = ring_pos_ff;
      run_in       = run_ff;
      peak_in      = peak_ff;
      slide_in     = slide_ff;
      last_in      = last_ff;
      k_in         = k_ff;
      s_in         = s_ff;
      d_in         = d_ff;
      num_in       = num_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cnt_vld_in   = cnt_vld_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Take a new character.
      if (cmd.accept) begin
         last_in = req_data.last;
         if (hit) begin
            cur_in   = cur_next;
            widx_in  = widx_next;
            slide_in = widx_next >= win_lim;
            k_in     = ring_k;
         end
      end

      // The oldest word leaves: its pairs with the remaining copies go.
      if (cmd.leave_wr && (cnt_eff != '0)) begin
         run_in = run_ff - PAIR_W'(cnt_wdata);
      end

      // The new word enters: it pairs with every copy already present.
      if (cmd.enter_wr) begin
         run_in = run_add;
         if (slide_ff && (run_add > peak_ff)) begin
            peak_in = run_add;
         end
         ring_pos_in = (k_plus >= win_ff) ? '0 : RING_AW'(k_plus);
      end

      if (cnt_we) begin
         cnt_vld_in[cnt_addr_ff] = 1'b1;
      end

      // Select the pair count and form the denominator.
      if (cmd.fin_mul) begin
         s_in = seq_slide ? peak_ff : run_ff;
         d_in = (seq_slide || n_pos) ? D_W'(mul_a) * D_W'(mul_b) : '0;
      end

      if (cmd.fin_num) begin
         num_in = NUM_W'(s_ff) * NUM_W'(dlcs_pkg::SCORE_SCALE) + NUM_W'(d_ff);
      end

      // Publish the result and start a fresh sequence.
      if (cmd.rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.dust_score  = (d_ff == '0) ? '0 : score_sat;
         rsp_data_in.pair_count  = PCW'(s_ff);
         cur_in                  = '0;
         widx_in                 = '0;
         ring_pos_in             = '0;
         run_in                  = '0;
         peak_in                 = '0;
         win_in                  = clamp_window(window_size);
         cnt_vld_in              = '0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= clamp_window(CFG_W'(dlcs_pkg::WINDOW_RESET));
         cur_ff       <= '0;
         widx_ff      <= '0;
         ring_pos_ff  <= '0;
         run_ff       <= '0;
         peak_ff      <= '0;
         slide_ff     <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_vld_ff   <= '0;
      end else begin
         win_ff       <= win_in;
         cur_ff       <= cur_in;
         widx_ff      <= widx_in;
         ring_pos_ff  <= ring_pos_in;
         run_ff       <= run_in;
         peak_ff      <= peak_in;
         slide_ff     <= slide_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_vld_ff   <= cnt_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      s_ff        <= s_in;
      d_ff        <= d_in;
      num_ff      <= num_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Count table: one registered read, one write.
   always_ff @(posedge clock) begin
      if (cmd.leave_rd || cmd.enter_rd) begin
         cnt_q_ff    <= cnt_mem[cnt_rd_addr];
         cnt_addr_ff <= cnt_rd_addr;
      end
      if (cnt_we) begin
         cnt_mem[cnt_addr_ff] <= cnt_wdata;
      end
   end

   // Window ring: the oldest word is read when a character is taken.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         ring_q_ff <= ring_mem[ring_k];
      end
      if (cmd.enter_wr) begin
         ring_mem[k_ff] <= cur_ff;
      end
   end

   dlcs_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (num_ff),
      .divisor  ({d_ff, 1'b0}),
      .done     (div_done),
      .quotient (quotient)
   );

   // Status toward the controller.
   always_comb begin
      status.in_word  = hit && (widx_next >= WIDX_W'(3));
      status.in_slide = widx_next >= win_lim;
      status.in_last  = req_data.last;
      status.last     = last_ff;
      status.d_zero   = d_ff == '0;
      status.div_done = div_done;
      status.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_widx_bound: assert property (@(posedge clock) disable iff (reset)
      widx_ff <= win_lim)
      else $error("word index ran past the window");

   a_ring_pos: assert property (@(posedge clock) disable iff (reset)
      WIN_W'(ring_pos_ff) < win_ff)
      else $error("ring position outside the active window");

   a_leave_count: assert property (@(posedge clock) disable iff (reset)
      cmd.leave_wr |-> (cnt_eff != '0))
      else $error("leaving word has no count");

   a_seq_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> ((widx_ff == '0) && (run_ff == '0) && (peak_ff == '0)))
      else $error("sequence state not cleared after a result");
`endif

endmodule

// ===== rtl/dlcs_ctrl.sv =====
// dlcs_ctrl: state machine that sequences count updates and the final scaling.
// Depends on dlcs_pkg; drives dlcs_datapath through cmd_type and reads status_type.
module dlcs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output dlcs_pkg::cmd_type    cmd,
   input  dlcs_pkg::status_type status
);

   dlcs_pkg::state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dlcs_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.in_word) begin
                  state_in = status.in_slide ? dlcs_pkg::ST_LEAVE_RD : dlcs_pkg::ST_ENTER_RD;
               end else if (status.in_last) begin
                  state_in = dlcs_pkg::ST_FIN_MUL;
               end
            end
         end
         dlcs_pkg::ST_LEAVE_RD: state_in = dlcs_pkg::ST_LEAVE_WR;
         dlcs_pkg::ST_LEAVE_WR: state_in = dlcs_pkg::ST_ENTER_RD;
         dlcs_pkg::ST_ENTER_RD: state_in = dlcs_pkg::ST_ENTER_WR;
         dlcs_pkg::ST_ENTER_WR: begin
            state_in = status.last ? dlcs_pkg::ST_FIN_MUL : dlcs_pkg::ST_IDLE;
         end
         dlcs_pkg::ST_FIN_MUL: state_in = dlcs_pkg::ST_FIN_NUM;
         dlcs_pkg::ST_FIN_NUM: begin
            state_in = status.d_zero ? dlcs_pkg::ST_FIN_OUT : dlcs_pkg::ST_FIN_START;
         end
         dlcs_pkg::ST_FIN_START: state_in = dlcs_pkg::ST_FIN_WAIT;
         dlcs_pkg::ST_FIN_WAIT: begin
            if (status.div_done) begin
               state_in = dlcs_pkg::ST_FIN_OUT;
            end
         end
         dlcs_pkg::ST_FIN_OUT: begin
            if (status.rsp_free) begin
               state_in = dlcs_pkg::ST_IDLE;
            end
         end
         default: state_in = dlcs_pkg::ST_IDLE;
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         dlcs_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         dlcs_pkg::ST_LEAVE_RD:  cmd.leave_rd  = 1'b1;
         dlcs_pkg::ST_LEAVE_WR:  cmd.leave_wr  = 1'b1;
         dlcs_pkg::ST_ENTER_RD:  cmd.enter_rd  = 1'b1;
         dlcs_pkg::ST_ENTER_WR:  cmd.enter_wr  = 1'b1;
         dlcs_pkg::ST_FIN_MUL:   cmd.fin_mul   = 1'b1;
         dlcs_pkg::ST_FIN_NUM:   cmd.fin_num   = 1'b1;
         dlcs_pkg::ST_FIN_START: cmd.div_start = 1'b1;
         dlcs_pkg::ST_FIN_WAIT:  cmd           = '0;
         dlcs_pkg::ST_FIN_OUT:   cmd.rsp_load  = status.rsp_free;
         default:                cmd           = '0;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dlcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/dust_low_complexity_score.sv =====
// dust_low_complexity_score: DUST-style triplet score; uses dlcs_pkg, dlcs_ctrl, dlcs_datapath.
// A skipped character is taken straight from idle; a base that completes a word goes through
// the enter read and write states, led by the leave read and write states once the window
// slides, for the count table's read-modify-write. The last item adds the scaling and division.
// Reset is synchronous: counts (by valid bits), scores and positions clear at once,
// window_size returns to 64, and no clearing pass is needed.
module dust_low_complexity_score #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dlcs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dlcs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dlcs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dlcs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dlcs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int CFG_W = dlcs_pkg::WINDOW_CFG_W;
   localparam int DW    = dlcs_pkg::CSR_DATA_W;
   localparam int AW    = dlcs_pkg::CSR_ADDR_W;

   logic [CFG_W-1:0]     window_size_ff, window_size_in;
   logic                 csr_write;
   dlcs_pkg::cmd_type    cmd;
   dlcs_pkg::status_type status;

   // Register port: the write lands in the access phase of a transfer.
   always_comb begin
      csr_pready     = 1'b1;
      csr_write      = csr_psel && csr_penable && csr_pwrite && csr_pready;
      window_size_in = window_size_ff;
      if (csr_write && (csr_paddr[AW-1] == dlcs_pkg::CSR_IDX_WINDOW_SIZE)) begin
         window_size_in = csr_pwdata[CFG_W-1:0];
      end
      csr_prdata = (csr_paddr[AW-1] == dlcs_pkg::CSR_IDX_WINDOW_SIZE) ?
                   DW'(window_size_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= CFG_W'(dlcs_pkg::WINDOW_RESET);
      end else begin
         window_size_ff <= window_size_in;
      end
   end

   dlcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   dlcs_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_data    (req_data),
      .window_size (window_size_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== tb/sv/dust_score_checker.sv =====
`timescale 1ns / 1ps
// dust_score_checker: watches the request, response and register ports of the DUST score block.
// It predicts each sequence's score from the accepted characters and compares every response.
// Depends on dlcs_pkg for the payload types and the window constants.
module dust_score_checker #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  dlcs_pkg::req_type                   req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  dlcs_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dlcs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dlcs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input  logic [dlcs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  pending
);

   // Register copy and the window latched for the sequence in progress.
   logic [dlcs_pkg::WINDOW_CFG_W-1:0] window_cfg;
   int                                active_w;

   // Per-sequence state of the predictor.
   int                                word_tally [dlcs_pkg::NUM_WORDS];
   logic [dlcs_pkg::WORD_W-1:0]       ring_words [MAX_WINDOW];
   logic [dlcs_pkg::WORD_W-1:0]       trip;
   int                                word_pos;
   int                                ring_at;
   int                                run_pairs;
   int                                peak_pairs;

   dlcs_pkg::rsp_type                 expected_scores [$];
   int                                errors = 0;

   assign fail_count = errors;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   // Maps a character to its two-bit base, or -1 when the character is skipped.
   function automatic int base_value(input logic [dlcs_pkg::BASE_W-1:0] c);
      case (c)
         "A", "a": return 0;
         "C", "c": return 1;
         "G", "g": return 2;
         "T", "t": return 3;
         default:  return -1;
      endcase
   endfunction

   function automatic int clamp_window(input logic [dlcs_pkg::WINDOW_CFG_W-1:0] v);
      if (int'(v) < dlcs_pkg::WINDOW_MIN) return dlcs_pkg::WINDOW_MIN;
      if (int'(v) > MAX_WINDOW) return MAX_WINDOW;
      return int'(v);
   endfunction

   task automatic restart_sequence();
      foreach (word_tally[i]) word_tally[i] = 0;
      trip = '0;
      word_pos = -3;
      ring_at = 0;
      run_pairs = 0;
      peak_pairs = 0;
      active_w = clamp_window(window_cfg);
   endtask

   // One counted base: the new word enters, and once the window is full the oldest leaves.
   task automatic take_base(input logic [1:0] b);
      int                          n;
      int                          k;
      logic [dlcs_pkg::WORD_W-1:0] gone;
      trip = {trip[dlcs_pkg::WORD_W-3:0], b};
      n = word_pos + 1;
      if (n > active_w) n = active_w;
      word_pos = n;
      if (n < 0) return;
      k = (ring_at >= active_w) ? 0 : ring_at;
      if (n >= active_w) begin
         gone = ring_words[k];
         if (word_tally[gone] != 0) begin
            word_tally[gone]--;
            run_pairs -= word_tally[gone];
         end
      end
      run_pairs += word_tally[trip];
      word_tally[trip]++;
      if (n >= active_w && run_pairs > peak_pairs) peak_pairs = run_pairs;
      ring_words[k] = trip;
      ring_at = (k + 1 >= active_w) ? 0 : k + 1;
   endtask

   // Score of the finished sequence, rounded half up, with a zero denominator giving zero.
   function automatic dlcs_pkg::rsp_type finish_score();
      dlcs_pkg::rsp_type r;
      int                s;
      int                d;
      int                score;
      if (word_pos >= active_w) begin
         s = peak_pairs;
         d = active_w * (active_w - 1);
      end else begin
         s = run_pairs;
         d = (word_pos > 0) ? word_pos * (word_pos + 1) : 0;
      end
      score = (d == 0) ? 0 : (dlcs_pkg::SCORE_SCALE * s + d) / (2 * d);
      if (score > dlcs_pkg::SCORE_MAX) score = dlcs_pkg::SCORE_MAX;
      r.dust_score = score[dlcs_pkg::SCORE_W-1:0];
      r.pair_count = s[dlcs_pkg::PAIR_COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      int                b;
      dlcs_pkg::rsp_type want;
      if (reset) begin
         window_cfg = dlcs_pkg::WINDOW_CFG_W'(dlcs_pkg::WINDOW_RESET);
         restart_sequence();
         expected_scores.delete();
      end else begin
         // Register port: track writes, check reads of the window register.
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[2] == dlcs_pkg::CSR_IDX_WINDOW_SIZE) begin
            if (csr_pwrite) begin
               window_cfg = csr_pwdata[dlcs_pkg::WINDOW_CFG_W-1:0];
            end else if (csr_prdata != dlcs_pkg::CSR_DATA_W'(window_cfg)) begin
               report_mismatch("window_size readback", int'(csr_prdata), int'(window_cfg));
            end
         end

         // Request transfer: feed the predictor; the last item yields one expected score.
         if (req_valid && !req_stall) begin
            if (req_data.has_base) begin
               b = base_value(req_data.base);
               if (b >= 0) take_base(b[1:0]);
            end
            if (req_data.last) begin
               expected_scores.push_back(finish_score());
               restart_sequence();
            end
         end

         // Response transfer: compare against the oldest expectation.
         if (rsp_valid && !rsp_stall) begin
            if (expected_scores.size() == 0) begin
               report_mismatch("response with none expected", int'(rsp_data.dust_score), 0);
            end else begin
               want = expected_scores.pop_front();
               if (rsp_data.dust_score != want.dust_score)
                  report_mismatch("dust_score", int'(rsp_data.dust_score),
                                  int'(want.dust_score));
               if (rsp_data.pair_count != want.pair_count)
                  report_mismatch("pair_count", int'(rsp_data.pair_count),
                                  int'(want.pair_count));
            end
         end
      end
      pending <= expected_scores.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives sequences and window settings into dust_low_complexity_score.
// Depends on dlcs_pkg, the block itself and dust_score_checker, which does all the checking.
module testbench;

   localparam int MAX_WINDOW  = 64;
   localparam int ITEM_GOAL   = 1200;
   localparam int SEQ_GOAL    = 60;
   localparam int DRAIN_WAIT  = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [dlcs_pkg::CSR_ADDR_W-1:0] ADDR_WINDOW_SIZE = 3'd0;
   localparam logic [dlcs_pkg::CSR_ADDR_W-1:0] ADDR_UNMAPPED    = 3'd4;

   typedef enum int {SEQ_MIXED, SEQ_REPEAT, SEQ_NOISY} seq_kind_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   dlcs_pkg::req_type                   req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   dlcs_pkg::rsp_type                   rsp_data;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [dlcs_pkg::CSR_ADDR_W-1:0]     csr_paddr = '0;
   logic [dlcs_pkg::CSR_DATA_W-1:0]     csr_pwdata = '0;
   logic [dlcs_pkg::CSR_DATA_W-1:0]     csr_prdata;
   logic                                csr_pready;

   int                                  fail_count;
   int                                  pending;
   int                                  cycles = 0;
   int                                  items_sent = 0;
   int                                  seqs_sent = 0;
   int                                  cfg_w = dlcs_pkg::WINDOW_RESET;
   int                                  live_w = dlcs_pkg::WINDOW_RESET;
   bit                                  steady = 1'b0;
   bit                                  short_only = 1'b0;
   bit                                  hold_go = 1'b0;
   bit                                  hold_seen = 1'b0;
   int                                  hold_left = 0;

   dust_low_complexity_score #(.MAX_WINDOW(MAX_WINDOW)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   dust_score_checker #(.MAX_WINDOW(MAX_WINDOW)) score_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready), .fail_count(fail_count), .pending(pending)
   );

   always #10 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Response side: random stalls, none while steady, and one long hold-off when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_seen) begin
         hold_seen <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 15);
      end
   end

   // Offers one item, with a random gap in front, and returns once it has transferred.
   task automatic send_char(input logic [dlcs_pkg::BASE_W-1:0] c, input bit has, input bit fin);
      while (!steady && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{base: c, has_base: has, last: fin};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (has || fin) items_sent++;
      if (fin) seqs_sent++;
   endtask

   function automatic logic [dlcs_pkg::BASE_W-1:0] any_base();
      logic [dlcs_pkg::BASE_W-1:0] c;
      case ($urandom_range(3))
         0:       c = "A";
         1:       c = "C";
         2:       c = "G";
         default: c = "T";
      endcase
      if ($urandom_range(1)) c = c | 8'h20;
      return c;
   endfunction

   function automatic int clamp_window(input int v);
      if (v < dlcs_pkg::WINDOW_MIN) return dlcs_pkg::WINDOW_MIN;
      if (v > MAX_WINDOW) return MAX_WINDOW;
      return v;
   endfunction

   // Length in characters: short ones, ones around the window filling, and long sliding ones.
   function automatic int pick_len();
      int r;
      r = $urandom_range(9);
      if (short_only || r < 4) return $urandom_range(0, 10);
      if (r < 8) return live_w - 1 + $urandom_range(0, 6);
      return $urandom_range(live_w + 9, 2 * live_w + 12);
   endfunction

   // One sequence; the last item either carries the final character or is an end-only item.
   task automatic send_sequence(input seq_kind_type kind, input int len);
      logic [dlcs_pkg::BASE_W-1:0] motif [4];
      logic [dlcs_pkg::BASE_W-1:0] c;
      int                          mlen;
      bit                          tail_only;
      mlen = $urandom_range(1, 4);
      foreach (motif[i]) motif[i] = any_base();
      tail_only = (len == 0) || ($urandom_range(9) < 2);
      for (int i = 0; i < len; i++) begin
         case (kind)
            SEQ_REPEAT: begin
               c = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : motif[i % mlen];
               if ($urandom_range(9) == 0) c = c ^ 8'h20;
            end
            SEQ_NOISY: c = ($urandom_range(1)) ? 8'($urandom_range(255)) : any_base();
            default:   c = ($urandom_range(99) < 15) ? 8'($urandom_range(255)) : any_base();
         endcase
         // An occasional item with neither a base nor an end, which the block ignores.
         if ($urandom_range(19) == 0) send_char(8'($urandom_range(255)), 1'b0, 1'b0);
         send_char(c, 1'b1, (i == len - 1) && !tail_only);
      end
      if (tail_only) send_char(8'($urandom_range(255)), 1'b0, 1'b1);
      // The block latches the register into its window after each result.
      live_w = clamp_window(cfg_w);
   endtask

   // Drops valid and waits until every score is back and the block has gone quiet.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // One register transfer: setup phase, access phase held until ready, then idle on the bus.
   task automatic csr_access(input bit wr, input logic [dlcs_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [dlcs_pkg::CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Writes the window register while the block is idle and reads it back.
   task automatic set_window(input logic [dlcs_pkg::CSR_DATA_W-1:0] value);
      drain();
      csr_access(1'b1, ADDR_WINDOW_SIZE, value);
      csr_access(1'b0, ADDR_WINDOW_SIZE, '0);
      cfg_w = int'(value[dlcs_pkg::WINDOW_CFG_W-1:0]);
   endtask

   task automatic run_phase(input int goal);
      int start;
      start = items_sent;
      while (items_sent - start < goal)
         send_sequence(seq_kind_type'($urandom_range(2)), pick_len());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty sequence, too few words, skipped codes and two all-repeat cases.
      send_char(8'h00, 1'b0, 1'b1);
      send_char("A", 1'b1, 1'b1);
      send_char("c", 1'b1, 1'b0);
      send_char("G", 1'b1, 1'b0);
      send_char("t", 1'b1, 1'b1);
      send_char("A", 1'b1, 1'b0);
      send_char("C", 1'b1, 1'b0);
      send_char("G", 1'b1, 1'b0);
      send_char("T", 1'b1, 1'b1);
      send_char("a", 1'b1, 1'b0);
      send_char(8'h00, 1'b1, 1'b0);
      send_char(8'h03, 1'b1, 1'b0);
      send_char("N", 1'b1, 1'b0);
      send_char(8'hFF, 1'b1, 1'b0);
      send_char("A", 1'b0, 1'b0);
      send_char("a", 1'b1, 1'b0);
      send_char("a", 1'b1, 1'b0);
      send_char("a", 1'b1, 1'b1);
      send_char("g", 1'b1, 1'b0);
      send_char("G", 1'b1, 1'b0);
      send_char("g", 1'b1, 1'b0);
      send_char("G", 1'b1, 1'b0);
      send_char(8'h80, 1'b0, 1'b1);

      // A homopolymer long enough to slide the full reset window: the largest pair count.
      for (int i = 0; i < 2 * dlcs_pkg::WINDOW_RESET; i++)
         send_char("A", 1'b1, i == 2 * dlcs_pkg::WINDOW_RESET - 1);
      run_phase(60);

      // Smallest windows, then the largest with no idling on either side.
      set_window(32'd3);
      run_phase(100);
      drain();
      csr_access(1'b1, ADDR_UNMAPPED, 32'd10);
      set_window(32'd4);
      run_phase(100);
      steady = 1'b1;
      set_window(32'd64);
      run_phase(150);
      steady = 1'b0;

      // Short sequences pile up results while the response side holds off.
      set_window(32'd5);
      short_only = 1'b1;
      hold_go <= 1'b1;
      run_phase(60);
      short_only = 1'b0;

      // Register values outside the window range are clamped; upper data bits are dropped.
      set_window(32'd127);
      run_phase(60);
      set_window(32'd0);
      run_phase(60);
      set_window(32'd2);
      run_phase(40);
      set_window(32'd65);
      run_phase(60);
      set_window(32'hFFFF_FF88);
      run_phase(60);

      while (items_sent < ITEM_GOAL || seqs_sent < SEQ_GOAL) begin
         set_window($urandom_range(dlcs_pkg::WINDOW_MIN, MAX_WINDOW));
         run_phase(100);
      end

      drain();
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dlcs_pkg.sv
rtl/dlcs_divider.sv
rtl/dlcs_datapath.sv
rtl/dlcs_ctrl.sv
rtl/dust_low_complexity_score.sv
tb/sv/dust_score_checker.sv
tb/sv/testbench.sv
